### sv/mrh_pkg.sv
// mrh_pkg: types, protocol constants and the read-only register table
// of the Modbus read-holding responder. No dependencies.
package mrh_pkg;

    typedef enum logic [2:0] {
        ST_RX,      // waiting for a request beat
        ST_RXCRC,   // shifting a request byte through the CRC
        ST_EVAL,    // frame ended: check and set up the answer
        ST_BYTE,    // produce the next response byte
        ST_TXCRC    // shifting a response byte through the CRC
    } t_state;

    typedef enum logic [2:0] {
        SEG_ADDR,
        SEG_FUNC,
        SEG_CNT,
        SEG_DATA,
        SEG_CRCLO,
        SEG_CRCHI
    } t_seg;

    localparam logic [7:0]  FUNC_READ = 8'h03;
    localparam logic [7:0]  FUNC_EXC  = 8'h83;
    localparam logic [7:0]  EXC_ADDR  = 8'h02;
    localparam logic [15:0] QTY_MAX   = 16'd125;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [3:0]  REQ_LEN   = 4'd8;
    localparam logic [3:0]  HDR_LEN   = 4'd6;
    localparam logic [3:0]  CNT_MAX   = 4'd15;

    // table contents; entries past the fourth read as zero
    function automatic logic [15:0] reg_value(input logic [6:0] idx);
        logic [15:0] v;
        case (idx)
            7'd0:    v = 16'd2300;
            7'd1:    v = 16'd512;
            7'd2:    v = 16'd1450;
            7'd3:    v = 16'd123;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

### sv/modbus_read_holding_responder_top.sv
// modbus_read_holding_responder_top: Modbus RTU read-holding-registers
// responder with a bit-serial CRC-16. Depends on mrh_pkg.
//
// Usage:
//   Slave stream: one request byte per beat on s_axis_tdata, s_axis_tlast
//   high on the last byte of the frame. Master stream: response bytes two
//   per beat, tdata = {byte_b, byte_a}, tuser = pair_full (byte_b valid),
//   tlast on the final beat of a response.
//   A frame is answered only if it is exactly 8 bytes, its CRC checks, the
//   function is 0x03 and the quantity is 1..125. A range past the table of
//   REG_COUNT words gives exception 0x02. The slave address is echoed.
// Timing:
//   The CRC is one shared 16-bit register updated one bit per cycle. Each
//   request byte is accepted and then shifted through the CRC bit by bit;
//   the frame-ending byte is followed by a frame check. Each response byte
//   that is covered by the CRC is shifted through it the same way; the two
//   CRC bytes are sent without shifts. No request beat is taken while a
//   response is being built.
// Reset clears the byte count, sets the CRC to 0xFFFF and drops any beat
// in flight. A stalled receiver holds the output beat; the next pair waits
// in the engine, and after the last beat is loaded new requests are
// accepted even while that beat still waits to be taken.
module modbus_read_holding_responder_top #(
    parameter int REG_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] byte_a, [15:8] byte_b
    output logic        m_axis_tuser,   // pair_full
    output logic        m_axis_tlast    // last
);

    localparam int IW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int HDR_SIZE = 6;

    // control state
    mrh_pkg::t_state r_state, n_state;
    mrh_pkg::t_seg   r_seg, n_seg;
    logic [3:0]      r_count, n_count;
    logic [15:0]     r_crc, n_crc;
    logic [2:0]      r_bit, n_bit;
    logic            r_end, n_end;
    logic            r_exc, n_exc;
    logic            r_hi, n_hi;
    logic            r_have_a, n_have_a;
    logic            r_ovalid, n_ovalid;

    // payload
    logic [7:0]      r_hdr [HDR_SIZE];
    logic [IW-1:0]   r_widx, n_widx;
    logic [6:0]      r_left, n_left;
    logic [7:0]      r_pa, n_pa;
    logic [7:0]      r_oa, n_oa;
    logic [7:0]      r_ob, n_ob;
    logic            r_ofull, n_ofull;
    logic            r_olast, n_olast;

    logic            w_in_acc;
    logic            w_out_free;
    logic [15:0]     w_start;
    logic [15:0]     w_qty;
    logic            w_ok;
    logic            w_range_bad;
    logic [15:0]     w_word;
    logic [7:0]      w_byte;
    logic            w_final;
    logic            w_go;
    logic [15:0]     w_crc_sh;

    assign s_axis_tready = (r_state == mrh_pkg::ST_RX);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_ovalid || m_axis_tready;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_ob, r_oa};
    assign m_axis_tuser  = r_ofull;
    assign m_axis_tlast  = r_olast;

    assign w_start = {r_hdr[2], r_hdr[3]};
    assign w_qty   = {r_hdr[4], r_hdr[5]};
    assign w_ok    = (r_count == mrh_pkg::REQ_LEN) && (r_crc == 16'd0)
                   && (r_hdr[1] == mrh_pkg::FUNC_READ)
                   && (w_qty != 16'd0) && (w_qty <= mrh_pkg::QTY_MAX);
    assign w_range_bad = ({1'b0, w_start} + {1'b0, w_qty}) > 17'(REG_COUNT);

    // one CRC bit step
    assign w_crc_sh = r_crc[0] ? ((r_crc >> 1) ^ mrh_pkg::CRC_POLY) : (r_crc >> 1);

    assign w_word = mrh_pkg::reg_value(7'(r_widx));

    always_comb begin
        case (r_seg)
            mrh_pkg::SEG_ADDR:  w_byte = r_hdr[0];
            mrh_pkg::SEG_FUNC:  w_byte = r_exc ? mrh_pkg::FUNC_EXC : mrh_pkg::FUNC_READ;
            mrh_pkg::SEG_CNT:   w_byte = r_exc ? mrh_pkg::EXC_ADDR : {r_left, 1'b0};
            mrh_pkg::SEG_DATA:  w_byte = r_hi ? w_word[15:8] : w_word[7:0];
            mrh_pkg::SEG_CRCLO: w_byte = r_crc[7:0];
            mrh_pkg::SEG_CRCHI: w_byte = r_crc[15:8];
            default:            w_byte = 8'd0;
        endcase
    end

    assign w_final = (r_seg == mrh_pkg::SEG_CRCHI);
    // the output register is only needed when a beat gets loaded
    assign w_go    = !(r_have_a || w_final) || w_out_free;

    always_comb begin
        n_state  = r_state;
        n_seg    = r_seg;
        n_count  = r_count;
        n_crc    = r_crc;
        n_bit    = r_bit;
        n_end    = r_end;
        n_exc    = r_exc;
        n_hi     = r_hi;
        n_have_a = r_have_a;
        n_widx   = r_widx;
        n_left   = r_left;
        n_pa     = r_pa;
        n_oa     = r_oa;
        n_ob     = r_ob;
        n_ofull  = r_ofull;
        n_olast  = r_olast;
        n_ovalid = r_ovalid && !m_axis_tready;

        case (r_state)
            mrh_pkg::ST_RX: begin
                if (w_in_acc) begin
                    n_crc   = r_crc ^ {8'd0, s_axis_tdata};
                    n_count = (r_count < mrh_pkg::CNT_MAX) ? r_count + 4'd1 : r_count;
                    n_end   = s_axis_tlast;
                    n_bit   = 3'd0;
                    n_state = mrh_pkg::ST_RXCRC;
                end
            end
            mrh_pkg::ST_RXCRC: begin
                n_crc = w_crc_sh;
                n_bit = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    n_state = r_end ? mrh_pkg::ST_EVAL : mrh_pkg::ST_RX;
                end
            end
            mrh_pkg::ST_EVAL: begin
                // count and CRC restart; the CRC preset also seeds the answer
                n_count  = 4'd0;
                n_crc    = mrh_pkg::CRC_INIT;
                n_exc    = w_range_bad;
                n_widx   = w_start[IW-1:0];
                n_left   = w_qty[6:0];
                n_hi     = 1'b1;
                n_have_a = 1'b0;
                n_seg    = mrh_pkg::SEG_ADDR;
                n_state  = w_ok ? mrh_pkg::ST_BYTE : mrh_pkg::ST_RX;
            end
            mrh_pkg::ST_BYTE: begin
                if (w_go) begin
                    // pair packing
                    if (!r_have_a && !w_final) begin
                        n_pa     = w_byte;
                        n_have_a = 1'b1;
                    end else begin
                        n_oa     = r_have_a ? r_pa : w_byte;
                        n_ob     = r_have_a ? w_byte : 8'd0;
                        n_ofull  = r_have_a;
                        n_olast  = w_final;
                        n_ovalid = 1'b1;
                        n_have_a = 1'b0;
                    end
                    // CRC feed for covered bytes
                    if (r_seg != mrh_pkg::SEG_CRCLO && r_seg != mrh_pkg::SEG_CRCHI) begin
                        n_crc   = r_crc ^ {8'd0, w_byte};
                        n_bit   = 3'd0;
                        n_state = mrh_pkg::ST_TXCRC;
                    end
                    // advance to the next byte
                    case (r_seg)
                        mrh_pkg::SEG_ADDR: n_seg = mrh_pkg::SEG_FUNC;
                        mrh_pkg::SEG_FUNC: n_seg = mrh_pkg::SEG_CNT;
                        mrh_pkg::SEG_CNT:  n_seg = r_exc ? mrh_pkg::SEG_CRCLO
                                                         : mrh_pkg::SEG_DATA;
                        mrh_pkg::SEG_DATA: begin
                            n_hi = !r_hi;
                            if (!r_hi) begin
                                n_widx = r_widx + IW'(1);
                                n_left = r_left - 7'd1;
                                if (r_left == 7'd1) begin
                                    n_seg = mrh_pkg::SEG_CRCLO;
                                end
                            end
                        end
                        mrh_pkg::SEG_CRCLO: n_seg = mrh_pkg::SEG_CRCHI;
                        mrh_pkg::SEG_CRCHI: begin
                            n_crc   = mrh_pkg::CRC_INIT;
                            n_state = mrh_pkg::ST_RX;
                        end
                        default: n_seg = mrh_pkg::SEG_ADDR;
                    endcase
                end
            end
            mrh_pkg::ST_TXCRC: begin
                n_crc = w_crc_sh;
                n_bit = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    n_state = mrh_pkg::ST_BYTE;
                end
            end
            default: n_state = mrh_pkg::ST_RX;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mrh_pkg::ST_RX;
            r_seg    <= mrh_pkg::SEG_ADDR;
            r_count  <= 4'd0;
            r_crc    <= mrh_pkg::CRC_INIT;
            r_bit    <= 3'd0;
            r_end    <= 1'b0;
            r_exc    <= 1'b0;
            r_hi     <= 1'b1;
            r_have_a <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seg    <= n_seg;
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_bit    <= n_bit;
            r_end    <= n_end;
            r_exc    <= n_exc;
            r_hi     <= n_hi;
            r_have_a <= n_have_a;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_widx  <= n_widx;
        r_left  <= n_left;
        r_pa    <= n_pa;
        r_oa    <= n_oa;
        r_ob    <= n_ob;
        r_ofull <= n_ofull;
        r_olast <= n_olast;
        if (w_in_acc && (r_count < mrh_pkg::HDR_LEN)) begin
            r_hdr[r_count[2:0]] <= s_axis_tdata;
        end
    end

endmodule

### test/modbus_read_holding_responder_top_tb.sv
// Testbench for modbus_read_holding_responder_top: request frames go in, response beats are
// predicted per accepted byte and checked one by one. Depends on mrh_pkg and the top level.
`timescale 1ns / 1ps

// Keeps its own copy of the responder state and builds the reply for each answered frame.
class reply_scoreboard;
    localparam int TABLE_WORDS = 32;

    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic       pair_full;
        logic       last;
    } beat_t;

    logic [3:0]  rx_count;
    logic [15:0] rx_crc;
    logic [7:0]  hdr [6];
    logic [15:0] holding [TABLE_WORDS];
    beat_t       beats_due [$];
    int          errors;
    int          beats_checked;
    int          frames_seen;
    int          reads_answered;
    int          exceptions_answered;

    function new();
        rx_count = '0;
        rx_crc   = 16'hFFFF;
        foreach (hdr[i]) hdr[i] = '0;
        foreach (holding[i]) holding[i] = '0;
        holding[0] = 16'd2300;
        holding[1] = 16'd512;
        holding[2] = 16'd1450;
        holding[3] = 16'd123;
        errors = 0;
        beats_checked = 0;
        frames_seen = 0;
        reads_answered = 0;
        exceptions_answered = 0;
    endfunction

    // Modbus CRC-16, reflected, one byte at a time
    static function logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    function int pending();
        return beats_due.size();
    endfunction

    // One accepted request byte; on the frame end the whole reply, if any, is queued.
    function void note_request_byte(input logic [7:0] b, input logic frame_end);
        logic [7:0]  reply [$];
        logic [15:0] start;
        logic [15:0] qty;
        logic [15:0] c;
        logic        ok;
        beat_t       bt;
        if (rx_count < 4'd6) hdr[rx_count] = b;
        rx_crc = crc_byte(rx_crc, b);
        if (rx_count < 4'd15) rx_count++;
        if (!frame_end) return;
        frames_seen++;
        ok    = (rx_count == 4'd8) && (rx_crc == 16'h0000) && (hdr[1] == mrh_pkg::FUNC_READ);
        start = {hdr[2], hdr[3]};
        qty   = {hdr[4], hdr[5]};
        if (qty == 16'd0 || qty > mrh_pkg::QTY_MAX) ok = 1'b0;
        rx_count = '0;
        rx_crc   = 16'hFFFF;
        if (!ok) return;
        reply.push_back(hdr[0]);
        if (32'(start) + 32'(qty) > TABLE_WORDS) begin
            reply.push_back(mrh_pkg::FUNC_EXC);
            reply.push_back(mrh_pkg::EXC_ADDR);
            exceptions_answered++;
        end else begin
            reply.push_back(mrh_pkg::FUNC_READ);
            reply.push_back(8'(qty * 2));
            for (int i = 0; i < int'(qty); i++) begin
                reply.push_back(holding[int'(start) + i][15:8]);
                reply.push_back(holding[int'(start) + i][7:0]);
            end
            reads_answered++;
        end
        c = 16'hFFFF;
        foreach (reply[i]) c = crc_byte(c, reply[i]);
        reply.push_back(c[7:0]);
        reply.push_back(c[15:8]);
        // two bytes per beat, odd tail goes out alone
        for (int i = 0; i < reply.size(); i += 2) begin
            bt.byte_a    = reply[i];
            bt.pair_full = (i + 1) < reply.size();
            bt.byte_b    = bt.pair_full ? reply[i + 1] : 8'h00;
            bt.last      = (i + 2) >= reply.size();
            beats_due.push_back(bt);
        end
    endfunction

    function void flag(input string what);
        errors++;
        if (errors <= 10) $display("[%0t] MISMATCH %s", $time, what);
    endfunction

    function void check_response_beat(input logic [15:0] data, input logic user,
                                      input logic last);
        beat_t want;
        beats_checked++;
        if (beats_due.size() == 0) begin
            flag($sformatf("unexpected beat data=%h user=%b last=%b", data, user, last));
            return;
        end
        want = beats_due.pop_front();
        if (data[7:0] !== want.byte_a || data[15:8] !== want.byte_b
                || user !== want.pair_full || last !== want.last)
            flag($sformatf("exp a=%h b=%h full=%b last=%b, got a=%h b=%h full=%b last=%b",
                           want.byte_a, want.byte_b, want.pair_full, want.last,
                           data[7:0], data[15:8], user, last));
    endfunction
endclass

module modbus_read_holding_responder_top_tb;

    localparam int LIMIT       = 2000000; // cycles before giving up
    localparam int SETTLE      = 800;     // longest reply build plus margin
    localparam int TABLE_WORDS = 32;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        s_axis_tlast;   // frame_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] byte_a, [15:8] byte_b
    logic        m_axis_tuser;   // pair_full
    logic        m_axis_tlast;   // last

    reply_scoreboard sb;
    logic [7:0]      req_bytes [$];
    int              cycle_cnt;
    int              random_bytes;
    bit              quiet;        // no idling on either side in the last stretch
    bit              send_choppy;
    bit              long_hold_done;

    modbus_read_holding_responder_top #(.REG_COUNT(TABLE_WORDS)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        cycle_cnt = 0;
        wait (cycle_cnt >= LIMIT);
        $display("timeout after %0d cycles", cycle_cnt);
        $display("end of test: mismatches");
        $finish;
    end

    // output beats checked at the rising edge
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_response_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);

    // receiver: calm and choppy stretches, plus one long hold-off to back up the block
    initial begin : rx_side
        int  stall_left;
        int  stretch_left;
        int  hold_left;
        bit  choppy;
        m_axis_tready = 1'b0;
        stall_left = 0;
        stretch_left = 0;
        hold_left = 0;
        choppy = 1'b0;
        long_hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && sb != null && sb.beats_checked >= 80) begin
                hold_left = 600;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    choppy = $urandom_range(0, 2) != 0;
                    stretch_left = $urandom_range(20, 120);
                end
                stretch_left--;
                if (choppy && !quiet && $urandom_range(0, 3) == 0) begin
                    stall_left = $urandom_range(1, 15) - 1;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // one request beat; held until the block takes it
    task automatic send_byte(input logic [7:0] b, input logic eof);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eof;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request_byte(b, eof);
        random_bytes++;
    endtask

    task automatic sender_gap();
        int n;
        if (quiet || !send_choppy || $urandom_range(0, 3) != 0) return;
        n = $urandom_range(1, 15);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic send_frame();
        send_choppy = $urandom_range(0, 2) != 0;
        for (int i = 0; i < req_bytes.size(); i++) begin
            send_byte(req_bytes[i], i == req_bytes.size() - 1);
            sender_gap();
        end
    endtask

    // request with a correct CRC appended
    task automatic build_req(input logic [7:0] addr, input logic [7:0] func,
                             input logic [15:0] start, input logic [15:0] qty);
        logic [15:0] c;
        req_bytes.delete();
        req_bytes.push_back(addr);
        req_bytes.push_back(func);
        req_bytes.push_back(start[15:8]);
        req_bytes.push_back(start[7:0]);
        req_bytes.push_back(qty[15:8]);
        req_bytes.push_back(qty[7:0]);
        c = 16'hFFFF;
        foreach (req_bytes[i]) c = sb.crc_byte(c, req_bytes[i]);
        req_bytes.push_back(c[7:0]);
        req_bytes.push_back(c[15:8]);
    endtask

    task automatic build_noise(input int len);
        req_bytes.delete();
        repeat (len) req_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic corrupt_one();
        int idx;
        idx = $urandom_range(0, req_bytes.size() - 1);
        req_bytes[idx] = req_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
    endtask

    task automatic send_req(input logic [7:0] addr, input logic [7:0] func,
                            input logic [15:0] start, input logic [15:0] qty);
        build_req(addr, func, start, qty);
        send_frame();
    endtask

    initial begin : main
        logic [15:0] start;
        logic [15:0] qty;
        int          kind;
        int          frames;
        bit          paused;
        sb = new();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        quiet = 1'b0;
        send_choppy = 1'b0;
        random_bytes = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: table edges, largest reply, exceptions and dropped frames
        send_req(8'h01, mrh_pkg::FUNC_READ, 16'd0, 16'd1);
        send_req(8'hFF, mrh_pkg::FUNC_READ, 16'd0, 16'd4);
        send_req(8'h00, mrh_pkg::FUNC_READ, 16'd0, 16'd32);      // full table, longest reply
        send_req(8'h5A, mrh_pkg::FUNC_READ, 16'd31, 16'd1);      // last word
        send_req(8'hA5, mrh_pkg::FUNC_READ, 16'd31, 16'd2);      // range just past the end
        send_req(8'h11, mrh_pkg::FUNC_READ, 16'hFFFF, 16'd125);  // far out, largest legal qty
        send_req(8'h22, mrh_pkg::FUNC_READ, 16'd0, 16'd0);       // zero quantity: dropped
        send_req(8'h33, mrh_pkg::FUNC_READ, 16'd0, 16'd126);     // over the quantity cap
        send_req(8'h44, mrh_pkg::FUNC_READ, 16'd0, 16'hFFFF);
        send_req(8'h55, 8'h04, 16'd0, 16'd1);                    // other function
        build_req(8'h66, mrh_pkg::FUNC_READ, 16'd1, 16'd2);      // bad CRC
        corrupt_one();
        send_frame();
        build_req(8'h77, mrh_pkg::FUNC_READ, 16'd2, 16'd2);      // one byte short
        void'(req_bytes.pop_back());
        send_frame();
        build_req(8'h88, mrh_pkg::FUNC_READ, 16'd2, 16'd2);      // one byte too many
        req_bytes.push_back(8'h00);
        send_frame();
        build_noise(20);                                         // byte count saturates
        send_frame();
        build_noise(1);                                          // frame end on the first byte
        send_frame();
        send_req(8'h99, mrh_pkg::FUNC_READ, 16'd2, 16'd2);       // state is clean again

        // random: mostly well-formed requests, some broken ones and noise
        frames = 0;
        paused = 1'b0;
        while (random_bytes < 450) begin
            kind  = $urandom_range(0, 99);
            start = 16'($urandom_range(0, 31));
            if ($urandom_range(0, 4) != 0)
                qty = 16'($urandom_range(1, (32 - int'(start)) < 4 ? 32 - int'(start) : 4));
            else
                qty = 16'($urandom_range(1, 32 - int'(start)));
            if (kind < 70) begin
                send_req(8'($urandom_range(0, 255)), mrh_pkg::FUNC_READ, start, qty);
            end else if (kind < 80) begin
                if ($urandom_range(0, 1) == 0) begin
                    start = 16'($urandom_range(0, 65535));
                    qty   = 16'($urandom_range(1, 125));
                    if (32'(start) + 32'(qty) <= 32) start = 16'd40;
                end else begin
                    qty = 16'($urandom_range(33 - int'(start), 125));
                end
                send_req(8'($urandom_range(0, 255)), mrh_pkg::FUNC_READ, start, qty);
            end else if (kind < 88) begin
                build_req(8'($urandom_range(0, 255)), mrh_pkg::FUNC_READ, start, qty);
                corrupt_one();
                send_frame();
            end else if (kind < 94) begin
                if ($urandom_range(0, 1) == 0)
                    send_req(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             start, qty);
                else
                    send_req(8'($urandom_range(0, 255)), mrh_pkg::FUNC_READ,
                             16'($urandom_range(0, 65535)),
                             $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(126, 65535)));
            end else begin
                build_noise($urandom_range(1, 20));
                send_frame();
            end
            frames++;
            // once, let the block drain completely before going on
            if (!paused && frames == 25) begin
                paused = 1'b1;
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
            if (random_bytes >= 380) quiet = 1'b1;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d frames: %0d read replies, %0d exception replies, %0d beats checked",
                 sb.frames_seen, sb.reads_answered, sb.exceptions_answered, sb.beats_checked);
        $display("long receiver hold-off %0s, %0d mismatches, %0d beats still due",
                 long_hold_done ? "seen" : "not reached", sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
